[rtl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int MAX_PATTERN_DEF = 8;
	localparam int MAX_REPL        = 8;
	localparam int QDEPTH          = MAX_REPL + 1;
	localparam int LEN_W           = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 2'd3;

	// item kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pattern;
		logic [CFG_DATA_W-1:0] repl;
		logic [LEN_W-1:0]      plen;
		logic [LEN_W-1:0]      rlen;
	} cfg_t;

endpackage

[rtl/sfr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration registers; presents clamped pattern and replacement lengths.
// ----------------------------------------------------------------------------
module sfr_cfg_regs #(
	parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sfr_pkg::cfg_t                    cfg,
	output logic                             win_clear
);

	localparam int WIN_DEPTH = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
	localparam logic [sfr_pkg::LEN_W-1:0] PCAP = sfr_pkg::LEN_W'(WIN_DEPTH);
	localparam logic [sfr_pkg::LEN_W-1:0] RCAP = sfr_pkg::LEN_W'(sfr_pkg::MAX_REPL);

	logic [sfr_pkg::CFG_DATA_W-1:0] pattern_q;
	logic [sfr_pkg::CFG_DATA_W-1:0] repl_q;
	logic [sfr_pkg::LEN_W-1:0]      plen_q;
	logic [sfr_pkg::LEN_W-1:0]      rlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			repl_q    <= '0;
			plen_q    <= sfr_pkg::LEN_W'(1);
			rlen_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sfr_pkg::REG_PATTERN_BYTES:     pattern_q <= cfg_data;
				sfr_pkg::REG_PATTERN_LEN:       plen_q    <= cfg_data[sfr_pkg::LEN_W-1:0];
				sfr_pkg::REG_REPLACEMENT_BYTES: repl_q    <= cfg_data;
				sfr_pkg::REG_REPLACEMENT_LEN:   rlen_q    <= cfg_data[sfr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// a new pattern length drops whatever the window holds
	assign win_clear = cfg_valid && (cfg_index == sfr_pkg::REG_PATTERN_LEN);

	always_comb begin
		cfg.pattern = pattern_q;
		cfg.repl    = repl_q;
		if (plen_q == '0)
			cfg.plen = sfr_pkg::LEN_W'(1);
		else if (plen_q > PCAP)
			cfg.plen = PCAP;
		else
			cfg.plen = plen_q;
		cfg.rlen = (rlen_q > RCAP) ? RCAP : rlen_q;
	end

endmodule

[rtl/stream_find_replace.sv]
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming substring find-and-replace over a byte stream.
// ----------------------------------------------------------------------------
// Path: input register, then the result queue, whose head entry drives the output.
// Throughput: one item per cycle while each item yields at most one result and
//   the output does not stall; an item with several results holds the output while
//   the result queue drains one entry per cycle unless the output stalls, and input stalls meanwhile.
// Reset: clears control state and sets configuration to defaults; window
//   bytes are not cleared and no clearing pass is run.
module stream_find_replace #(
	parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_stall,
	input  sfr_pkg::in_item_t              src_item,
	output logic                           res_valid,
	input  logic                           res_stall,
	output sfr_pkg::out_item_t             res_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int WIN_DEPTH = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
	localparam int QD        = sfr_pkg::QDEPTH;
	localparam int QCNT_W    = $clog2(QD + 1);
	localparam int LW        = sfr_pkg::LEN_W;

	sfr_pkg::cfg_t cfg;
	logic          win_clear;

	sfr_cfg_regs #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.win_clear (win_clear)
	);

	assign cfg_ready = 1'b1;

	// input register
	logic              valid_s1;
	sfr_pkg::in_item_t item_s1;

	// window state
	logic [7:0]       win_q [WIN_DEPTH];
	logic [CNT_W-1:0] cnt_q;

	// result queue, head entry is the output register
	sfr_pkg::out_item_t qbuf_q [QD];
	logic [QCNT_W-1:0]  qcnt_q;

	logic pop, proc;

	assign res_valid = (qcnt_q != '0);
	assign res_item  = qbuf_q[0];
	assign pop       = res_valid && !res_stall;
	assign proc      = valid_s1 && ((qcnt_q == '0) || ((qcnt_q == QCNT_W'(1)) && pop));
	assign src_stall = valid_s1 && !proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (src_valid && !src_stall)
			valid_s1 <= 1'b1;
		else if (proc)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall)
			item_s1 <= src_item;
	end

	// per-item datapath
	logic [LW-1:0]      cnt0, pos, fill, nres;
	logic               lead, match;
	logic [7:0]         wsh  [WIN_DEPTH];
	logic [7:0]         wnew [WIN_DEPTH];
	logic [7:0]         rb   [sfr_pkg::MAX_REPL];
	logic [WIN_DEPTH-1:0] eq;
	sfr_pkg::out_item_t ld [QD];
	logic [CNT_W-1:0]   cnt_nxt;

	always_comb begin
		cnt0 = (LW'(cnt_q) > cfg.plen) ? cfg.plen : LW'(cnt_q);
		lead = (cnt0 >= cfg.plen);
		pos  = lead ? (cnt0 - LW'(1)) : cnt0;
		fill = pos + LW'(1);

		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (lead && (i < WIN_DEPTH - 1))
				wsh[i] = win_q[i + 1];
			else
				wsh[i] = win_q[i];
		end
		for (int i = 0; i < WIN_DEPTH; i++) begin
			wnew[i] = (LW'(i) == pos) ? item_s1.ch : wsh[i];
			eq[i]   = (wnew[i] == cfg.pattern[8*i +: 8]) || (LW'(i) >= cfg.plen);
		end
		match = (fill == cfg.plen) && (&eq);

		for (int j = 0; j < sfr_pkg::MAX_REPL; j++)
			rb[j] = cfg.repl[8*j +: 8];

		for (int k = 0; k < QD; k++)
			ld[k] = '0;

		if (item_s1.kind == sfr_pkg::KIND_END) begin
			// flush the window; an empty one gives a bare end marker
			for (int k = 0; k < WIN_DEPTH; k++) begin
				ld[k].out_char = win_q[k];
				ld[k].has_char = 1'b1;
				ld[k].last     = (LW'(k + 1) == cnt0);
			end
			if (cnt0 == '0) begin
				ld[0].out_char = '0;
				ld[0].has_char = 1'b0;
				ld[0].last     = 1'b1;
				nres           = LW'(1);
			end else begin
				nres = cnt0;
			end
			cnt_nxt = '0;
		end else begin
			for (int k = 0; k < QD; k++) begin
				ld[k].has_char = 1'b1;
				ld[k].last     = 1'b0;
				if (lead) begin
					if (k == 0)
						ld[k].out_char = win_q[0];
					else
						ld[k].out_char = rb[k - 1];
				end else if (k < sfr_pkg::MAX_REPL) begin
					ld[k].out_char = rb[k];
				end else begin
					ld[k].out_char = '0;
				end
			end
			nres    = LW'(lead) + (match ? cfg.rlen : LW'(0));
			cnt_nxt = match ? CNT_W'(0) : CNT_W'(fill);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (win_clear)
			cnt_q <= '0;
		else if (proc)
			cnt_q <= cnt_nxt;
	end

	always_ff @(posedge clk) begin
		if (proc && (item_s1.kind == sfr_pkg::KIND_CHAR))
			win_q <= wnew;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			qcnt_q <= '0;
		else if (proc)
			qcnt_q <= QCNT_W'(nres);
		else if (pop)
			qcnt_q <= qcnt_q - QCNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			qbuf_q <= ld;
		end else if (pop) begin
			for (int k = 0; k < QD - 1; k++)
				qbuf_q[k] <= qbuf_q[k + 1];
		end
	end

`ifndef SYNTHESIS
	a_qcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= QCNT_W'(QD))
		else $error("result queue count out of range");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(cnt_q) <= LW'(WIN_DEPTH))
		else $error("window count beyond depth");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (item_s1.kind == sfr_pkg::KIND_END) |=> cnt_q == '0)
		else $error("window not cleared after end of string");

	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.last |-> qcnt_q == QCNT_W'(1))
		else $error("last result is not the final queued entry");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		proc |-> qcnt_q <= QCNT_W'(1))
		else $error("queue reloaded while results pending");
`endif

endmodule
